@@ hdl/msep_pkg.sv @@
// Shared types, MIDI byte codes and helper functions of the MIDI stream event parser.
package msep_pkg;

  // Width of the event fields on the result channel
  localparam int unsigned IDX_W  = 11;
  localparam int unsigned RAW_W  = 7;
  localparam int unsigned NORM_W = 16;
  localparam int unsigned SRC_W  = 8;
  localparam int unsigned TS_W   = 64;
  localparam int unsigned OUT_TDATA_W = 112;

  // Event kinds
  localparam logic KIND_NOTE = 1'b0;
  localparam logic KIND_CC   = 1'b1;

  // MIDI byte codes
  localparam logic [7:0] ST_CHANNEL_LO = 8'h80;
  localparam logic [7:0] ST_CHANNEL_HI = 8'hEF;
  localparam logic [7:0] MSG_MASK      = 8'hF0;
  localparam logic [7:0] CHAN_MASK     = 8'h0F;
  localparam logic [7:0] MSG_NOTE_OFF  = 8'h80;
  localparam logic [7:0] MSG_NOTE_ON   = 8'h90;
  localparam logic [7:0] MSG_CTRL      = 8'hB0;
  localparam logic [7:0] MSG_PROGRAM   = 8'hC0;
  localparam logic [7:0] MSG_CH_PRESS  = 8'hD0;
  localparam logic [7:0] ST_SYSEX      = 8'hF0;
  localparam logic [7:0] ST_MTC_QF     = 8'hF1;
  localparam logic [7:0] ST_SONG_POS   = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL   = 8'hF3;
  localparam logic [7:0] ST_EOX        = 8'hF7;
  localparam logic [7:0] ST_REALTIME   = 8'hF8;

  // Reciprocal of 127 scaled by 2**29, exact for dividends below 2**22
  localparam logic [22:0] RECIP_127  = 23'd4227331;
  localparam int unsigned RECIP_SHIFT = 29;

  typedef struct packed {
    logic              kind;
    logic [IDX_W-1:0]  index;
    logic [RAW_W-1:0]  raw;
    logic [NORM_W-1:0] norm;
    logic [SRC_W-1:0]  source;
    logic [TS_W-1:0]   time_us;
  } event_t;

  function automatic logic is_channel(input logic [7:0] st);
    is_channel = st inside {[ST_CHANNEL_LO:ST_CHANNEL_HI]};
  endfunction

  // Number of data bytes that follow a status byte
  function automatic logic [1:0] length_of(input logic [7:0] st);
    logic [7:0] msg;
    msg = st & MSG_MASK;
    if (is_channel(st)) begin
      length_of = (msg inside {MSG_PROGRAM, MSG_CH_PRESS}) ? 2'd1 : 2'd2;
    end else if (st inside {ST_MTC_QF, ST_SONG_SEL}) begin
      length_of = 2'd1;
    end else if (st == ST_SONG_POS) begin
      length_of = 2'd2;
    end else begin
      length_of = 2'd0;
    end
  endfunction

  // round(raw / 127) in unsigned Q1.15: (raw * 32768 + 63) / 127
  function automatic logic [NORM_W-1:0] norm_of(input logic [RAW_W-1:0] raw);
    logic [21:0] x;
    logic [44:0] p;
    x = {raw, 15'd0} + 22'd63;
    p = 45'(x) * 45'(RECIP_127);
    norm_of = p[44:RECIP_SHIFT];
  endfunction

endpackage

@@ hdl/msep_parser.sv @@
// Running-status parser core: keeps parser state; one event per completed note or CC message.
module msep_parser #(
  parameter int unsigned SOURCE_ID_WIDTH = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_fire,
  input  logic [SOURCE_ID_WIDTH-1:0] in_source,
  input  logic [7:0]                 in_byte,
  input  logic [63:0]                in_time,
  output logic                       res_valid,
  output msep_pkg::event_t           res
);

  typedef struct packed {
    logic       rv;
    logic [7:0] rs;
    logic       pv;
    logic [7:0] ps;
    logic [1:0] ec;
  } status_t;

  // Status fields after a new status byte
  function automatic status_t start_status(input logic [7:0] st);
    status_t s;
    s.rv = msep_pkg::is_channel(st);
    s.rs = s.rv ? st : 8'd0;
    s.ec = msep_pkg::length_of(st);
    s.pv = (s.ec != 2'd0);
    s.ps = s.pv ? st : 8'd0;
    start_status = s;
  endfunction

  logic                       running_valid_r, running_valid_nxt;
  logic [7:0]                 running_status_r, running_status_nxt;
  logic                       pending_valid_r, pending_valid_nxt;
  logic [7:0]                 pending_status_r, pending_status_nxt;
  logic [1:0]                 expected_r, expected_nxt;
  logic [1:0]                 received_r, received_nxt;
  logic [6:0]                 first_data_r, first_data_nxt;
  logic                       in_sysex_r, in_sysex_nxt;
  logic                       source_known_r, source_known_nxt;
  logic [SOURCE_ID_WIDTH-1:0] last_source_r, last_source_nxt;

  status_t    st_new;
  logic [7:0] done_status;
  logic [7:0] done_msg;
  logic [6:0] done_val;

  always_comb begin
    running_valid_nxt  = running_valid_r;
    running_status_nxt = running_status_r;
    pending_valid_nxt  = pending_valid_r;
    pending_status_nxt = pending_status_r;
    expected_nxt       = expected_r;
    received_nxt       = received_r;
    first_data_nxt     = first_data_r;
    in_sysex_nxt       = in_sysex_r;
    source_known_nxt   = source_known_r;
    last_source_nxt    = last_source_r;
    st_new             = '0;
    done_status        = '0;
    done_msg           = '0;
    done_val           = '0;
    res_valid          = 1'b0;
    res                = '0;

    if (in_fire) begin
      // A new source starts from a clean parser
      if (source_known_r && (last_source_r != in_source)) begin
        running_valid_nxt  = 1'b0;
        running_status_nxt = '0;
        pending_valid_nxt  = 1'b0;
        pending_status_nxt = '0;
        expected_nxt       = '0;
        received_nxt       = '0;
        in_sysex_nxt       = 1'b0;
      end
      source_known_nxt = 1'b1;
      last_source_nxt  = in_source;

      if (in_byte[7]) begin
        // Real-time bytes leave the parser state untouched
        if (in_byte < msep_pkg::ST_REALTIME) begin
          if (in_byte == msep_pkg::ST_SYSEX || in_byte == msep_pkg::ST_EOX) begin
            running_valid_nxt  = 1'b0;
            running_status_nxt = '0;
            pending_valid_nxt  = 1'b0;
            pending_status_nxt = '0;
            expected_nxt       = '0;
            received_nxt       = '0;
            in_sysex_nxt       = (in_byte == msep_pkg::ST_SYSEX);
          end else begin
            in_sysex_nxt       = 1'b0;
            st_new             = start_status(in_byte);
            running_valid_nxt  = st_new.rv;
            running_status_nxt = st_new.rs;
            pending_valid_nxt  = st_new.pv;
            pending_status_nxt = st_new.ps;
            expected_nxt       = st_new.ec;
            received_nxt       = '0;
          end
        end
      end else if (!in_sysex_nxt) begin
        // Data under running status reopens the message
        if (!pending_valid_nxt && running_valid_nxt) begin
          st_new             = start_status(running_status_nxt);
          running_valid_nxt  = st_new.rv;
          running_status_nxt = st_new.rs;
          pending_valid_nxt  = st_new.pv;
          pending_status_nxt = st_new.ps;
          expected_nxt       = st_new.ec;
          received_nxt       = '0;
        end
        if (pending_valid_nxt) begin
          if (expected_nxt == 2'd0 || received_nxt >= 2'd2) begin
            pending_valid_nxt  = 1'b0;
            pending_status_nxt = '0;
            expected_nxt       = '0;
            received_nxt       = '0;
          end else begin
            if (received_nxt == 2'd0) begin
              first_data_nxt = in_byte[6:0];
            end
            received_nxt = received_nxt + 2'd1;
            if (received_nxt == expected_nxt) begin
              done_status = pending_status_nxt;
              done_msg    = done_status & msep_pkg::MSG_MASK;
              done_val    = (expected_nxt > 2'd1) ? in_byte[6:0] : 7'd0;

              res.index   = {done_status[3:0], first_data_nxt};
              res.source  = 8'(in_source);
              res.time_us = in_time;
              if (done_msg == msep_pkg::MSG_NOTE_OFF) begin
                res_valid = 1'b1;
                res.kind  = msep_pkg::KIND_NOTE;
                res.raw   = '0;
              end else if (done_msg == msep_pkg::MSG_NOTE_ON) begin
                res_valid = 1'b1;
                res.kind  = msep_pkg::KIND_NOTE;
                res.raw   = done_val;
              end else if (done_msg == msep_pkg::MSG_CTRL) begin
                res_valid = 1'b1;
                res.kind  = msep_pkg::KIND_CC;
                res.raw   = done_val;
              end
              res.norm = msep_pkg::norm_of(res.raw);

              pending_valid_nxt  = 1'b0;
              pending_status_nxt = '0;
              expected_nxt       = '0;
              received_nxt       = '0;
              if (running_valid_nxt && running_status_nxt == done_status) begin
                st_new             = start_status(done_status);
                running_valid_nxt  = st_new.rv;
                running_status_nxt = st_new.rs;
                pending_valid_nxt  = st_new.pv;
                pending_status_nxt = st_new.ps;
                expected_nxt       = st_new.ec;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_valid_r  <= 1'b0;
      running_status_r <= '0;
      pending_valid_r  <= 1'b0;
      pending_status_r <= '0;
      expected_r       <= '0;
      received_r       <= '0;
      first_data_r     <= '0;
      in_sysex_r       <= 1'b0;
      source_known_r   <= 1'b0;
      last_source_r    <= '0;
    end else begin
      running_valid_r  <= running_valid_nxt;
      running_status_r <= running_status_nxt;
      pending_valid_r  <= pending_valid_nxt;
      pending_status_r <= pending_status_nxt;
      expected_r       <= expected_nxt;
      received_r       <= received_nxt;
      first_data_r     <= first_data_nxt;
      in_sysex_r       <= in_sysex_nxt;
      source_known_r   <= source_known_nxt;
      last_source_r    <= last_source_nxt;
    end
  end

endmodule

@@ hdl/midi_stream_event_parser.sv @@
// Top level of the MIDI stream event parser: input stream, parser core and output skid stage.
// Events: the byte that completes a note or control change message writes its event to the
//   output register, or to the skid register if the output stalls; other bytes give none.
// Throughput: one byte per cycle; in_tready drops only while the skid register holds a
//   second result behind the output register.
// Reset (rst_n, synchronous, active low) clears running status, the pending message, the
//   sysex flag and the known source, and empties both output registers.
module midi_stream_event_parser #(
  parameter int unsigned SOURCE_ID_WIDTH = 8,
  localparam int unsigned IN_TDATA_W = ((SOURCE_ID_WIDTH + 72 + 7) / 8) * 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata fields, low bit up: source_id, data_byte[7:0], timestamp_us[63:0], zero pad
  input  logic [IN_TDATA_W-1:0]                in_tdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // out_tdata fields, low bit up: control_index[10:0], raw_value[6:0],
  //   normalized_value[15:0], event_source[7:0], event_time_us[63:0], zero pad
  output logic [msep_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // out_tuser fields: event_kind (0 note, 1 control change)
  output logic                                 out_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready
);

  localparam int unsigned W = SOURCE_ID_WIDTH;
  localparam int unsigned EV_DATA_W = msep_pkg::IDX_W + msep_pkg::RAW_W + msep_pkg::NORM_W
                                    + msep_pkg::SRC_W + msep_pkg::TS_W;

  logic                in_fire;
  logic                res_valid;
  msep_pkg::event_t    res;

  // Output register and the skid register behind it
  logic                out_valid_r;
  msep_pkg::event_t    out_ev_r;
  logic                skid_valid_r;
  msep_pkg::event_t    skid_ev_r;
  logic                take;

  // Accept while the skid register is free: the output register may still hold a result
  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign take      = out_valid_r && out_tready;

  msep_parser #(
    .SOURCE_ID_WIDTH(SOURCE_ID_WIDTH)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_source (in_tdata[W-1:0]),
    .in_byte   (in_tdata[W+7:W]),
    .in_time   (in_tdata[W+71:W+8]),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      // No transaction on the input side here; drain the skid when the output moves
      if (take) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_r || take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take) begin
        out_ev_r <= skid_ev_r;
      end
    end else if (res_valid) begin
      if (!out_valid_r || take) begin
        out_ev_r <= res;
      end else begin
        skid_ev_r <= res;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ev_r.kind;
  assign out_tdata  = {(msep_pkg::OUT_TDATA_W - EV_DATA_W)'(0),
                       out_ev_r.time_us, out_ev_r.source, out_ev_r.norm,
                       out_ev_r.raw, out_ev_r.index};

endmodule

@@ hdl/msep_checker.sv @@
// Port-level checker of the MIDI stream event parser and its bind to the top level.
module msep_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tready,
  input logic [msep_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic                              out_tuser,
  input logic                              out_tvalid,
  input logic                              out_tready
);

  logic [6:0]  raw;
  logic [15:0] norm;

  assign raw  = out_tdata[17:11];
  assign norm = out_tdata[33:18];

  // Reset empties the output side and opens the input
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid && in_tready)
    else $error("output not empty after reset");

  // Input back-pressure only when a result already waits at the output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !$past(out_tready) || out_tvalid)
    else $error("input stalled with empty output");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // The normalized value tracks the raw value
  a_norm_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((raw == 7'd0) == (norm == 16'd0)))
    else $error("normalized value zero mismatch");

  a_norm_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((raw == 7'd127) == (norm == 16'h8000)) && (norm <= 16'h8000))
    else $error("normalized value full scale mismatch");

endmodule

bind midi_stream_event_parser msep_checker u_msep_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
